// ===== hdl/tpe_pkg.sv =====
package tpe_pkg;

  localparam int CoordFracBits = 16;
  localparam int ProgFrac      = 16;

  localparam int TimeW  = 48;
  localparam int CoordW = 32;
  localparam int TripW  = 17;
  localparam int NumW   = 42;
  localparam int DivAW  = 24;
  localparam int DivDW  = 18;
  localparam int QuotW  = 23;
  localparam int ProgW  = 24;
  localparam int T2W    = 29;

  localparam logic [TripW-1:0] TripMinMs = 17'd5000;
  localparam logic [TripW-1:0] TripMaxMs = 17'd120000;

  localparam logic signed [ProgW-1:0] ProgMax = 24'sd4194304;
  localparam logic signed [ProgW-1:0] ProgOne = 24'sd65536;

  typedef enum logic [2:0] {
    RegStart,
    RegTarget,
    RegControl,
    RegLength,
    RegFirstSpeed,
    RegLastSpeed,
    RegMode,
    RegLaunch
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0]      start_pt;
    logic [63:0]      target_pt;
    logic [63:0]      control_pt;
    logic [TimeW-1:0] launch;
    logic [1:0]       mode;
    logic [TripW-1:0] tm;
    logic [17:0]      tm2;
    logic [22:0]      tm64;
    logic [23:0]      tm126;
    logic             trip_ok;
  } cfg_t;

  typedef struct packed {
    logic lt;
    logic sat;
  } div_side_t;

endpackage

// ===== hdl/trajectory_position_evaluator.sv =====
// throughput: one beat per cycle; a stalled output freezes the whole pipeline
// the 23-stage progress divider and the two multiplier stages set the depth
// after reset and after every config write the trip time is recomputed
// serially, with s_axis_tready_o low meanwhile
module trajectory_position_evaluator
  import tpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // time_ms
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // pos_x, pos_y
  output logic        m_axis_tuser_o,   // clipped
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int AxLat = 4;

  cfg_t cfg;
  logic adv;

  logic               v1_q, v2_q;
  logic signed [48:0] el_q;
  logic [DivAW-1:0]   a_q;
  logic [DivDW-1:0]   d_q;
  div_side_t          sd_q;

  logic signed [48:0] lo_sum, x;
  logic               lt, sat;
  logic [DivAW-1:0]   a_d;
  logic [DivDW-1:0]   d_d;

  logic               dv;
  logic [QuotW-1:0]   quot;
  div_side_t          dside;

  logic                    vp1_q, vp2_q, vp3_q;
  logic signed [ProgW-1:0] p_d, p1_q, p2_q, p3_q;
  logic                    c1_q, c2_q, c3_q;
  logic signed [47:0]      pp_d;
  logic [47:0]             pp_q;
  logic [T2W-1:0]          t2_q;

  logic [AxLat-1:0] va_q, ca_q;
  logic [CoordW-1:0] pos_x, pos_y;
  logic              clip_x, clip_y;

  tpe_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  assign adv             = !va_q[AxLat-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv && cfg.trip_ok;

  always_comb begin
    lo_sum = el_q + $signed({26'b0, cfg.tm64});
    x      = el_q - $signed({32'b0, cfg.tm});
    lt     = el_q < $signed({32'b0, cfg.tm});
    if (lt) begin
      sat = lo_sum < 49'sd0;
      a_d = sat ? '0 : lo_sum[DivAW-1:0];
      d_d = {1'b0, cfg.tm};
    end else begin
      sat = x > $signed({25'b0, cfg.tm126});
      a_d = sat ? '0 : x[DivAW-1:0];
      d_d = cfg.tm2;
    end
    if (dside.sat) begin
      p_d = dside.lt ? -ProgMax : ProgMax;
    end else if (dside.lt) begin
      p_d = $signed({1'b0, quot}) - ProgMax;
    end else begin
      p_d = $signed({1'b0, quot}) + ProgOne;
    end
    pp_d = p1_q * p1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      vp1_q <= 1'b0;
      vp2_q <= 1'b0;
      vp3_q <= 1'b0;
      va_q  <= '0;
    end else if (adv) begin
      v1_q  <= s_axis_tvalid_i && cfg.trip_ok;
      v2_q  <= v1_q;
      vp1_q <= dv;
      vp2_q <= vp1_q;
      vp3_q <= vp2_q;
      va_q  <= {va_q[AxLat-2:0], vp3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      el_q <= $signed({1'b0, s_axis_tdata_i}) - $signed({1'b0, cfg.launch});
      a_q  <= a_d;
      d_q  <= d_d;
      sd_q <= '{lt: lt, sat: sat};
      p1_q <= p_d;
      c1_q <= dside.sat;
      pp_q <= pp_d;
      p2_q <= p1_q;
      c2_q <= c1_q;
      t2_q <= T2W'((pp_q + 48'd32768) >> ProgFrac);
      p3_q <= p2_q;
      c3_q <= c2_q;
      ca_q <= {ca_q[AxLat-2:0], c3_q};
    end
  end

  tpe_div u_div (
    .clk_i,
    .rst_ni,
    .en_i    (adv),
    .valid_i (v2_q),
    .a_i     (a_q),
    .d_i     (d_q),
    .side_i  (sd_q),
    .valid_o (dv),
    .quot_o  (quot),
    .side_o  (dside)
  );

  tpe_axis u_axis_x (
    .clk_i,
    .en_i   (adv),
    .p_i    (p3_q),
    .t2_i   (t2_q),
    .bez_i  (cfg.mode[0]),
    .s_i    ($signed(cfg.start_pt[31:0])),
    .c_i    ($signed(cfg.control_pt[31:0])),
    .e_i    ($signed(cfg.target_pt[31:0])),
    .pos_o  (pos_x),
    .clip_o (clip_x)
  );

  tpe_axis u_axis_y (
    .clk_i,
    .en_i   (adv),
    .p_i    (p3_q),
    .t2_i   (t2_q),
    .bez_i  (cfg.mode[0]),
    .s_i    ($signed(cfg.start_pt[63:32])),
    .c_i    ($signed(cfg.control_pt[63:32])),
    .e_i    ($signed(cfg.target_pt[63:32])),
    .pos_o  (pos_y),
    .clip_o (clip_y)
  );

  assign m_axis_tvalid_o = va_q[AxLat-1];
  assign m_axis_tdata_o  = {pos_y, pos_x};
  assign m_axis_tuser_o  = ca_q[AxLat-1] | clip_x | clip_y;

  a_prog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vp1_q |-> (p1_q >= -ProgMax) && (p1_q <= ProgMax))
    else $error("progress outside saturation range");

endmodule

// ===== hdl/tpe_cfg.sv =====
module tpe_cfg
  import tpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output cfg_t        cfg_o
);

  localparam logic [31:0] RampFloor  = 32'(10 << CoordFracBits);
  localparam logic [31:0] ConstFloor = 32'(1 << CoordFracBits);

  logic [63:0]      start_q, target_q, control_q;
  logic [31:0]      len_q, fs_q, ls_q;
  logic [1:0]       mode_q;
  logic [TimeW-1:0] launch_q;

  logic             load_q, ok_q;
  logic [5:0]       cnt_q;
  logic [NumW-1:0]  nq_q;
  logic [31:0]      rem_q, speed_q;
  logic [TripW-1:0] tm_q;
  logic [17:0]      tm2_q;
  logic [22:0]      tm64_q;
  logic [23:0]      tm126_q;

  logic [32:0]      spd_sum;
  logic [31:0]      spd_mean, speed;
  logic [NumW-1:0]  num;
  logic [32:0]      rsh;
  logic             ge;
  logic [TripW-1:0] tm_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      target_q  <= '0;
      control_q <= '0;
      len_q     <= '0;
      fs_q      <= '0;
      ls_q      <= '0;
      mode_q    <= '0;
      launch_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegStart:      start_q   <= cfg_data_i;
        RegTarget:     target_q  <= cfg_data_i;
        RegControl:    control_q <= cfg_data_i;
        RegLength:     len_q     <= cfg_data_i[31:0];
        RegFirstSpeed: fs_q      <= cfg_data_i[31:0];
        RegLastSpeed:  ls_q      <= cfg_data_i[31:0];
        RegMode:       mode_q    <= cfg_data_i[1:0];
        RegLaunch:     launch_q  <= cfg_data_i[TimeW-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    spd_sum  = {1'b0, fs_q} + {1'b0, ls_q};
    spd_mean = spd_sum[32:1];
    if (mode_q[1]) begin
      speed = (spd_mean < RampFloor) ? RampFloor : spd_mean;
    end else begin
      speed = (fs_q < ConstFloor) ? ConstFloor : fs_q;
    end
    num = NumW'(len_q) * NumW'(1000);
    rsh = {rem_q, nq_q[NumW-1]};
    ge  = rsh >= {1'b0, speed_q};
    if (nq_q < NumW'(TripMinMs)) begin
      tm_d = TripMinMs;
    end else if (nq_q > NumW'(TripMaxMs)) begin
      tm_d = TripMaxMs;
    end else begin
      tm_d = nq_q[TripW-1:0];
    end
  end

  // serial trip-time divider, restarted by every write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b1;
      ok_q   <= 1'b0;
      cnt_q  <= '0;
    end else if (cfg_valid_i) begin
      load_q <= 1'b1;
      ok_q   <= 1'b0;
    end else if (load_q) begin
      load_q <= 1'b0;
      cnt_q  <= 6'(NumW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 6'd1;
    end else if (!ok_q) begin
      ok_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!cfg_valid_i && load_q) begin
      nq_q    <= num;
      rem_q   <= '0;
      speed_q <= speed;
    end else if (!cfg_valid_i && cnt_q != '0) begin
      rem_q <= ge ? 32'(rsh - {1'b0, speed_q}) : rsh[31:0];
      nq_q  <= {nq_q[NumW-2:0], ge};
    end else if (!cfg_valid_i && !ok_q) begin
      tm_q    <= tm_d;
      tm2_q   <= {tm_d, 1'b0};
      tm64_q  <= {tm_d, 6'b0};
      tm126_q <= {tm_d, 7'b0} - {6'b0, tm_d, 1'b0};
    end
  end

  assign cfg_o = '{
    start_pt:   start_q,
    target_pt:  target_q,
    control_pt: control_q,
    launch:     launch_q,
    mode:       mode_q,
    tm:         tm_q,
    tm2:        tm2_q,
    tm64:       tm64_q,
    tm126:      tm126_q,
    trip_ok:    ok_q
  };

  a_trip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok_q |-> (tm_q >= TripMinMs) && (tm_q <= TripMaxMs))
    else $error("trip time out of range");

  a_trip_mult: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok_q |-> tm126_q == 24'(tm_q) * 24'd126)
    else $error("derived trip bound mismatch");

endmodule

// ===== hdl/tpe_div.sv =====
module tpe_div
  import tpe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DivAW-1:0] a_i,
  input  logic [DivDW-1:0] d_i,
  input  div_side_t        side_i,
  output logic             valid_o,
  output logic [QuotW-1:0] quot_o,
  output div_side_t        side_o
);

  localparam int Pre  = QuotW - ProgFrac;
  localparam int Last = QuotW - 1;

  logic             v_q  [QuotW];
  logic [DivDW-1:0] r_q  [QuotW];
  logic [QuotW-1:0] q_q  [QuotW];
  logic [DivAW-1:0] a_q  [QuotW];
  logic [DivDW-1:0] d_q  [QuotW];
  div_side_t        sd_q [QuotW];

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    localparam int K = QuotW - 1 - s;
    logic             v_in;
    logic [DivDW-1:0] r_in;
    logic [QuotW-1:0] q_in;
    logic [DivAW-1:0] a_in;
    logic [DivDW-1:0] d_in;
    div_side_t        sd_in;
    logic             nb;
    logic [DivDW:0]   t;
    logic             ge;

    if (s == 0) begin : g_first
      assign v_in  = valid_i;
      assign r_in  = DivDW'(a_i >> Pre);
      assign q_in  = '0;
      assign a_in  = a_i;
      assign d_in  = d_i;
      assign sd_in = side_i;
    end else begin : g_next
      assign v_in  = v_q[s-1];
      assign r_in  = r_q[s-1];
      assign q_in  = q_q[s-1];
      assign a_in  = a_q[s-1];
      assign d_in  = d_q[s-1];
      assign sd_in = sd_q[s-1];
    end

    if (K >= ProgFrac) begin : g_bit
      assign nb = a_in[K-ProgFrac];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign t  = {r_in, nb};
    assign ge = t >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]  <= ge ? DivDW'(t - {1'b0, d_in}) : t[DivDW-1:0];
        q_q[s]  <= {q_in[QuotW-2:0], ge};
        a_q[s]  <= a_in;
        d_q[s]  <= d_in;
        sd_q[s] <= sd_in;
      end
    end
  end

  assign valid_o = v_q[Last];
  assign quot_o  = q_q[Last];
  assign side_o  = sd_q[Last];

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Last] |-> r_q[Last] < d_q[Last])
    else $error("divider remainder not reduced");

  a_quot_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Last] |-> (40'(q_q[Last]) * 40'(d_q[Last]) + 40'(r_q[Last]))
                  == {a_q[Last], 16'b0})
    else $error("divider result inconsistent");

endmodule

// ===== hdl/tpe_axis.sv =====
module tpe_axis
  import tpe_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [ProgW-1:0]  p_i,
  input  logic [T2W-1:0]           t2_i,
  input  logic                     bez_i,
  input  logic signed [CoordW-1:0] s_i,
  input  logic signed [CoordW-1:0] c_i,
  input  logic signed [CoordW-1:0] e_i,
  output logic [CoordW-1:0]        pos_o,
  output logic                     clip_o
);

  logic signed [32:0] d1;
  logic signed [34:0] k;
  logic signed [56:0] m1_d, m1_q;
  logic signed [64:0] m2_d, m2_q;
  logic signed [66:0] acc_d, acc_q, accr;
  logic signed [51:0] sum_d, sum_q;
  logic [CoordW-1:0]  pos_d;
  logic               clip_d;

  always_comb begin
    d1   = bez_i ? (33'(c_i) - 33'(s_i)) : (33'(e_i) - 33'(s_i));
    k    = 35'(s_i) - (35'(c_i) <<< 1) + 35'(e_i);
    m1_d = 57'(p_i) * 57'(d1);
    m2_d = 65'($signed({1'b0, t2_i})) * 65'(k);
    acc_d = bez_i ? ((67'(m1_q) <<< 1) + 67'(m2_q)) : 67'(m1_q);
    accr  = (acc_q + 67'sd32768) >>> ProgFrac;
    sum_d = 52'(s_i) + 52'(accr);
    if (sum_q > 52'sd2147483647) begin
      pos_d  = 32'h7fff_ffff;
      clip_d = 1'b1;
    end else if (sum_q < -52'sd2147483648) begin
      pos_d  = 32'h8000_0000;
      clip_d = 1'b1;
    end else begin
      pos_d  = sum_q[CoordW-1:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= m1_d;
      m2_q   <= m2_d;
      acc_q  <= acc_d;
      sum_q  <= sum_d;
      pos_o  <= pos_d;
      clip_o <= clip_d;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import tpe_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  trajectory_position_evaluator u_dut (.*);

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic        clipped;
  } position_t;

  class position_scoreboard;
    logic [63:0] start_pt, target_pt, control_pt;
    logic [31:0] length, speed_a, speed_b;
    logic [1:0]  mode;
    logic [47:0] launch;
    position_t   pending[$];
    int          mismatches;
    int          checked;

    function void reset_regs();
      start_pt = '0; target_pt = '0; control_pt = '0;
      length = '0; speed_a = '0; speed_b = '0; mode = '0; launch = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] val);
      case (idx)
        RegStart:      start_pt = val;
        RegTarget:     target_pt = val;
        RegControl:    control_pt = val;
        RegLength:     length = val[31:0];
        RegFirstSpeed: speed_a = val[31:0];
        RegLastSpeed:  speed_b = val[31:0];
        RegMode:       mode = val[1:0];
        default:       launch = val[47:0];
      endcase
    endfunction

    function longint trip_time();
      longint spd, q;
      if (mode[1]) begin
        spd = (longint'(speed_a) + longint'(speed_b)) >>> 1;
        if (spd < (longint'(10) << 16)) spd = longint'(10) << 16;
      end else begin
        spd = longint'(speed_a);
        if (spd < (longint'(1) << 16)) spd = longint'(1) << 16;
      end
      q = (longint'(length) * 1000) / spd;
      if (q < 5000) q = 5000;
      if (q > 120000) q = 120000;
      return q;
    endfunction

    function longint round16(longint v);
      return (v + (longint'(1) << 15)) >>> 16;
    endfunction

    function longint coord(longint s, longint c, longint e, longint p, longint t2);
      longint acc;
      if (mode[0]) acc = 2 * p * (c - s) + t2 * (s - 2 * c + e);
      else acc = p * (e - s);
      return s + round16(acc);
    endfunction

    function logic [31:0] clamp32(longint v, inout logic clip);
      if (v > 64'sd2147483647) begin
        clip = 1'b1;
        return 32'h7fffffff;
      end
      if (v < -64'sd2147483648) begin
        clip = 1'b1;
        return 32'h80000000;
      end
      return v[31:0];
    endfunction

    function void note_time(logic [47:0] t_ms);
      longint tm, el, p, t2, lo, x;
      logic clip;
      position_t r;
      tm = trip_time();
      el = longint'({16'd0, t_ms}) - longint'({16'd0, launch});
      clip = 1'b0;
      if (el < tm) begin
        lo = -64 * tm;
        if (el < lo) begin
          p = -64 * 65536;
          clip = 1'b1;
        end else p = ((el - lo) * 65536) / tm - 64 * 65536;
      end else begin
        x = el - tm;
        if (x > 126 * tm) begin
          p = 64 * 65536;
          clip = 1'b1;
        end else p = 65536 + (x * 65536) / (2 * tm);
      end
      t2 = round16(p * p);
      r.pos_x = clamp32(coord(longint'($signed(start_pt[31:0])),
        longint'($signed(control_pt[31:0])), longint'($signed(target_pt[31:0])),
        p, t2), clip);
      r.pos_y = clamp32(coord(longint'($signed(start_pt[63:32])),
        longint'($signed(control_pt[63:32])), longint'($signed(target_pt[63:32])),
        p, t2), clip);
      r.clipped = clip;
      pending.push_back(r);
    endfunction

    function void check_position(logic [63:0] data, logic clip);
      position_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h %b", data, clip);
        return;
      end
      e = pending.pop_front();
      if (e.pos_x !== data[31:0] || e.pos_y !== data[63:32] || e.clipped !== clip) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp x=%h y=%h c=%b got x=%h y=%h c=%b",
                   e.pos_x, e.pos_y, e.clipped, data[31:0], data[63:32], clip);
      end
    endfunction
  endclass

  position_scoreboard sb = new();
  longint cycles = 0;
  bit     calm = 1'b0;
  int     in_count = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_position(m_axis_tdata_o, m_axis_tuser_o);
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      m_axis_tready_i <= 1'b1;
      n = $urandom_range(1, 40);
      repeat (n) @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_time(logic [47:0] t_ms);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= t_ms;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_time(t_ms);
    in_count++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'h7fffffff - $urandom_range(0, 3);
      2: return 32'h80000000 + $urandom_range(0, 3);
      default: return $urandom_range(0, 32'h01ffffff) - 32'h00ffffff;
    endcase
  endfunction

  function automatic logic [47:0] near_time(logic [47:0] base);
    case ($urandom_range(0, 9))
      0: return 48'({$urandom(), $urandom()});
      1: return base - 48'($urandom_range(0, 8000000));
      2: return base + 48'($urandom_range(0, 16000000));
      default: return base + 48'($urandom_range(0, 250000)) - 48'd20000;
    endcase
  endfunction

  task automatic random_config();
    write_reg(RegStart, {rand_coord(), rand_coord()});
    write_reg(RegTarget, {rand_coord(), rand_coord()});
    write_reg(RegControl, {rand_coord(), rand_coord()});
    case ($urandom_range(0, 3))
      0: write_reg(RegLength, 64'(32'hffffffff));
      1: write_reg(RegLength, '0);
      default: write_reg(RegLength, 64'($urandom_range(0, 32'h0fffffff)));
    endcase
    write_reg(RegFirstSpeed, $urandom_range(0, 3) == 0 ? 64'($urandom()) :
              64'($urandom_range(0, 32'h003fffff)));
    write_reg(RegLastSpeed, $urandom_range(0, 3) == 0 ? 64'($urandom()) :
              64'($urandom_range(0, 32'h003fffff)));
    write_reg(RegMode, 64'($urandom_range(0, 3)));
    write_reg(RegLaunch, {16'd0, $urandom(), 16'($urandom())});
  endtask

  initial begin
    sb.reset_regs();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero config: trip clamps to minimum
    send_time('0);
    send_time(48'd5000);
    send_time(48'hffffffffffff);
    drain();

    // straight line at the extremes
    write_reg(RegStart, {32'h80000000, 32'h7fffffff});
    write_reg(RegTarget, {32'h7fffffff, 32'h80000000});
    write_reg(RegControl, 64'hffffffffffffffff);
    write_reg(RegLength, 64'(32'hffffffff));
    write_reg(RegFirstSpeed, '0);
    write_reg(RegLastSpeed, 64'(32'hffffffff));
    write_reg(RegMode, 64'd0);
    write_reg(RegLaunch, 64'h0000800000000000);
    send_time(48'h800000000000);
    send_time(48'h800000000000 - 48'd1);
    send_time(48'h800000000000 + 48'd120000);
    send_time(48'h800000000000 - 48'd7680000);
    send_time(48'h800000000000 - 48'd7680001);
    send_time(48'h800000000000 + 48'd15240000);
    send_time(48'h800000000000 + 48'd15240001);
    send_time('0);
    send_time(48'hffffffffffff);
    drain();

    // ramped bezier with small coordinates
    write_reg(RegStart, {32'h00010000, 32'hffff0000});
    write_reg(RegTarget, {32'h00640000, 32'h00c80000});
    write_reg(RegControl, {32'h00320000, 32'hff9c0000});
    write_reg(RegLength, 64'(32'h01000000));
    write_reg(RegFirstSpeed, 64'(32'h00020000));
    write_reg(RegLastSpeed, 64'(32'h00100000));
    write_reg(RegMode, 64'd3);
    write_reg(RegLaunch, 64'd1000);
    send_time(48'd1000);
    send_time(48'd0);
    send_time(48'd30000);
    send_time(48'd60000);
    send_time(48'd200000);
    drain();
    write_reg(RegMode, 64'd1);
    send_time(48'd40000);
    drain();

    for (int ph = 0; ph < 34; ph++) begin
      random_config();
      if (ph == 30) calm = 1'b1;
      for (int k = 0; k < 50; k++) begin
        send_time(near_time(sb.launch));
        if (ph == 5 && k == 25) drain();
      end
      drain();
    end

    $display("run covered %0d time samples, %0d positions checked, over 37 path setups",
             in_count, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/tpe_pkg.sv
hdl/tpe_cfg.sv
hdl/tpe_div.sv
hdl/tpe_axis.sv
hdl/trajectory_position_evaluator.sv
dv/tb_top.sv
